@@ rtl/ball_balance_pid_frame_assert.svh @@
// Assertion macros used by the ball balance PID frame controller RTL.
`ifndef BALL_BALANCE_PID_FRAME_ASSERT_SVH
`define BALL_BALANCE_PID_FRAME_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBPID_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBPID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bbpid_pkg.sv @@
// Package with widths, constants and command types of the ball balance PID frame block.
package bbpid_pkg;

   localparam int POS_FRAC_BITS  = 4;
   localparam int GAIN_FRAC_BITS = 8;
   localparam int TILT_SHIFT     = POS_FRAC_BITS + GAIN_FRAC_BITS;

   localparam int POS_W      = 14;
   localparam int DT_W       = 10;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 14;
   localparam int CODE_W     = 15;
   localparam int BYTE_W     = 8;
   localparam int ERR_W      = 21;
   localparam int PERR_W     = 22;
   localparam int INTEG_W    = 40;
   localparam int INTEG_SPLIT = 20;
   localparam int ACC_W      = 58;
   localparam int MUL_A_W    = 24;
   localparam int MUL_B_W    = 17;
   localparam int PROD_W     = 41;
   localparam int DIV_BITS   = 22;
   localparam int DIV_CNT_W  = 5;
   localparam int U_W        = 17;
   localparam int REM_W      = 14;
   localparam int DIGIT_W    = 7;
   localparam int BYTE_IDX_W = 3;

   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 24;

   localparam logic [CSR_ADDR_W-1:0] CSR_PROP_GAIN  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INTEG_GAIN = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DERIV_GAIN = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TILT_LIMIT = 2'd3;

   localparam logic [GAIN_W-1:0]  PROP_GAIN_RESET  = 16'd1280;
   localparam logic [GAIN_W-1:0]  INTEG_GAIN_RESET = 16'd128;
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RESET = 16'd1280;
   localparam logic [LIMIT_W-1:0] TILT_LIMIT_RESET = 14'd3000;

   // Velocity scale 60 is built as 64 - 4, the setpoint scale 4 as a shift.
   localparam int SETPOINT_SHIFT = 2;
   localparam int VEL_SHIFT_HI   = 6;
   localparam int VEL_SHIFT_LO   = 2;

   localparam int TILT_OFFSET = 9000;
   localparam int TILT_MAX    = 9000;
   // The floored tilt is biased to a non-negative value before the divide by five.
   localparam int DIV5_BIAS   = (TILT_MAX + 2) * 5;
   localparam int CODE_BIAS   = DIV5_BIAS / 5 - TILT_OFFSET;
   localparam int RECIP5       = 52429;
   localparam int RECIP5_SHIFT = 18;
   localparam int RECIP100       = 10486;
   localparam int RECIP100_SHIFT = 20;
   localparam int DIGIT_BASE  = 100;
   localparam int HI_BASE     = 10000;

   localparam logic [BYTE_W-1:0] CMD_TILT   = 8'd1;
   localparam logic [BYTE_W-1:0] TERMINATOR = 8'hFF;

   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   localparam int MUL_SEL_W = 4;
   localparam logic [MUL_SEL_W-1:0] MUL_NONE      = 4'd0;
   localparam logic [MUL_SEL_W-1:0] MUL_ERR_DT    = 4'd1;
   localparam logic [MUL_SEL_W-1:0] MUL_PG_ERR    = 4'd2;
   localparam logic [MUL_SEL_W-1:0] MUL_IG_LO     = 4'd3;
   localparam logic [MUL_SEL_W-1:0] MUL_IG_HI     = 4'd4;
   localparam logic [MUL_SEL_W-1:0] MUL_DG_DERIV  = 4'd5;
   localparam logic [MUL_SEL_W-1:0] MUL_RECIP5    = 4'd6;
   localparam logic [MUL_SEL_W-1:0] MUL_RECIP100  = 4'd7;
   localparam logic [MUL_SEL_W-1:0] MUL_BASE100   = 4'd8;

   localparam int ACC_OP_W = 2;
   localparam logic [ACC_OP_W-1:0] ACC_HOLD   = 2'd0;
   localparam logic [ACC_OP_W-1:0] ACC_LOAD   = 2'd1;
   localparam logic [ACC_OP_W-1:0] ACC_ADD    = 2'd2;
   localparam logic [ACC_OP_W-1:0] ACC_ADD_HI = 2'd3;

   localparam logic [BYTE_IDX_W-1:0] BYTE_CMD  = 3'd0;
   localparam logic [BYTE_IDX_W-1:0] BYTE_HI   = 3'd1;
   localparam logic [BYTE_IDX_W-1:0] BYTE_MID  = 3'd2;
   localparam logic [BYTE_IDX_W-1:0] BYTE_LO   = 3'd3;
   localparam logic [BYTE_IDX_W-1:0] BYTE_TERM = 3'd4;

   typedef struct packed {
      logic                  load;
      logic                  div_init;
      logic                  div_step;
      logic                  integ_upd;
      logic [MUL_SEL_W-1:0]  mul_sel;
      logic [ACC_OP_W-1:0]   acc_op;
      logic                  clamp;
      logic                  code_set;
      logic                  split;
      logic                  mid_set;
      logic                  lo_set;
      logic [BYTE_IDX_W-1:0] byte_idx;
   } bbpid_cmd_type;

endpackage

@@ rtl/bbpid_datapath.sv @@
// Datapath of the ball balance PID frame block: registers, shared multiplier, divider, digits.
module bbpid_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bbpid_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [bbpid_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [bbpid_pkg::REQ_DATA_W-1:0] req_tdata,
   input  bbpid_pkg::bbpid_cmd_type         cmd,
   output logic [bbpid_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bbpid_pkg::*;

   logic [GAIN_W-1:0]  prop_gain_ff;
   logic [GAIN_W-1:0]  integ_gain_ff;
   logic [GAIN_W-1:0]  deriv_gain_ff;
   logic [LIMIT_W-1:0] tilt_limit_ff;

   logic [POS_W-1:0]          prev_pos_ff;
   logic signed [PERR_W-1:0]  prev_err_ff;
   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [INTEG_W-1:0] integ_in;

   logic [POS_W-1:0]          ball_pos;
   logic [POS_W-1:0]          target_pos;
   logic [DT_W-1:0]           dt_ms;
   logic [DT_W-1:0]           dt_ff;
   logic signed [PERR_W-1:0]  sp_diff;
   logic signed [PERR_W-1:0]  mv_diff;
   logic signed [PERR_W-1:0]  err_wide;
   logic signed [ERR_W-1:0]   err_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   prod_acc;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [INTEG_W:0]   integ_sum;

   logic signed [PERR_W-1:0]  div_diff;
   logic [PERR_W-1:0]         div_num_ff;
   logic [PERR_W-1:0]         div_num_in;
   logic [DT_W-1:0]           div_rem_ff;
   logic [DT_W-1:0]           div_rem_in;
   logic                      div_neg_ff;
   logic [DT_W:0]             div_trial;
   logic                      div_ge;
   logic signed [PERR_W-1:0]  deriv;

   logic [LIMIT_W-1:0]        lim;
   logic [LIMIT_W-1:0]        lim_ff;
   logic [U_W-1:0]            lim5;
   logic signed [ACC_W-1:0]   hi_th;
   logic signed [ACC_W-1:0]   lo_th;
   logic signed [U_W-1:0]     tilt_x;
   logic signed [U_W:0]       u_wide;
   logic [U_W-1:0]            u_ff;
   logic                      over_ff;
   logic                      under_ff;

   logic [CODE_W-1:0]         quot5;
   logic [CODE_W-1:0]         code_in;
   logic [CODE_W-1:0]         code_ff;
   logic                      hi_in;
   logic                      hi_ff;
   logic [REM_W-1:0]          rem_in;
   logic [REM_W-1:0]          rem_ff;
   logic [DIGIT_W-1:0]        mid_ff;
   logic [DIGIT_W-1:0]        lo_ff;
   logic [BYTE_W-1:0]         tx_byte;

   assign ball_pos   = req_tdata[POS_W-1:0];
   assign target_pos = req_tdata[2*POS_W-1:POS_W];
   assign dt_ms      = req_tdata[2*POS_W+DT_W-1:2*POS_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= PROP_GAIN_RESET;
         integ_gain_ff <= INTEG_GAIN_RESET;
         deriv_gain_ff <= DERIV_GAIN_RESET;
         tilt_limit_ff <= TILT_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata;
            CSR_INTEG_GAIN: integ_gain_ff <= csr_wdata;
            CSR_DERIV_GAIN: deriv_gain_ff <= csr_wdata;
            CSR_TILT_LIMIT: tilt_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Error is the setpoint error scaled by 4 minus the velocity scaled by 60, both in position units.
   always_comb begin
      sp_diff  = $signed(PERR_W'(target_pos)) - $signed(PERR_W'(ball_pos));
      mv_diff  = $signed(PERR_W'(ball_pos)) - $signed(PERR_W'(prev_pos_ff));
      err_wide = (sp_diff <<< SETPOINT_SHIFT)
               - ((mv_diff <<< VEL_SHIFT_HI) - (mv_diff <<< VEL_SHIFT_LO));
   end

   always_comb begin
      case (cmd.mul_sel)
         MUL_ERR_DT: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = $signed(MUL_B_W'(dt_ff));
         end
         MUL_PG_ERR: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = $signed(MUL_B_W'(prop_gain_ff));
         end
         MUL_IG_LO: begin
            mul_a = $signed(MUL_A_W'(integ_ff[INTEG_SPLIT-1:0]));
            mul_b = $signed(MUL_B_W'(integ_gain_ff));
         end
         MUL_IG_HI: begin
            mul_a = MUL_A_W'($signed(integ_ff[INTEG_W-1:INTEG_SPLIT]));
            mul_b = $signed(MUL_B_W'(integ_gain_ff));
         end
         MUL_DG_DERIV: begin
            mul_a = MUL_A_W'(deriv);
            mul_b = $signed(MUL_B_W'(deriv_gain_ff));
         end
         MUL_RECIP5: begin
            mul_a = $signed(MUL_A_W'(u_ff));
            mul_b = $signed(MUL_B_W'(RECIP5));
         end
         MUL_RECIP100: begin
            mul_a = $signed(MUL_A_W'(rem_ff));
            mul_b = $signed(MUL_B_W'(RECIP100));
         end
         MUL_BASE100: begin
            mul_a = $signed(MUL_A_W'(mid_ff));
            mul_b = $signed(MUL_B_W'(DIGIT_BASE));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod_acc = ACC_W'(prod_ff);

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD:   acc_in = prod_acc;
         ACC_ADD:    acc_in = acc_ff + prod_acc;
         ACC_ADD_HI: acc_in = acc_ff + (prod_acc <<< INTEG_SPLIT);
         default:    acc_in = acc_ff;
      endcase
   end

   always_comb begin
      integ_sum = (INTEG_W+1)'(integ_ff) + (INTEG_W+1)'(prod_ff);
      if (integ_gain_ff == '0) begin
         integ_in = '0;
      end else if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_in = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_in = integ_sum[INTEG_W-1:0];
      end
   end

   // Restoring divider, one quotient bit per step; the quotient replaces the numerator.
   always_comb begin
      div_diff   = PERR_W'(err_ff) - prev_err_ff;
      div_trial  = {div_rem_ff, div_num_ff[PERR_W-1]};
      div_ge     = div_trial >= (DT_W+1)'(dt_ff);
      div_rem_in = div_ge ? DT_W'(div_trial - (DT_W+1)'(dt_ff)) : div_trial[DT_W-1:0];
      div_num_in = {div_num_ff[PERR_W-2:0], div_ge};
      deriv      = div_neg_ff ? -$signed(div_num_ff) : $signed(div_num_ff);
   end

   // Beyond the clamp thresholds the tilt saturates; inside them the floored tilt is
   // the shifted output divided by five.
   always_comb begin
      lim    = (tilt_limit_ff > LIMIT_W'(TILT_MAX)) ? LIMIT_W'(TILT_MAX) : tilt_limit_ff;
      lim5   = (U_W'(lim) << 2) + U_W'(lim);
      hi_th  = $signed(ACC_W'(lim5 + U_W'(5))) <<< TILT_SHIFT;
      lo_th  = -($signed(ACC_W'(lim5)) <<< TILT_SHIFT);
      tilt_x = acc_ff[TILT_SHIFT+U_W-1:TILT_SHIFT];
      u_wide = (U_W+1)'(tilt_x) + (U_W+1)'(DIV5_BIAS);
   end

   always_comb begin
      quot5 = prod_ff[RECIP5_SHIFT+CODE_W-1:RECIP5_SHIFT];
      if (over_ff) begin
         code_in = CODE_W'(TILT_OFFSET) + CODE_W'(lim_ff);
      end else if (under_ff) begin
         code_in = CODE_W'(TILT_OFFSET) - CODE_W'(lim_ff);
      end else begin
         code_in = quot5 - CODE_W'(CODE_BIAS);
      end
      hi_in  = code_ff >= CODE_W'(HI_BASE);
      rem_in = hi_in ? REM_W'(code_ff - CODE_W'(HI_BASE)) : REM_W'(code_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pos_ff <= '0;
         prev_err_ff <= '0;
         integ_ff    <= '0;
      end else begin
         if (cmd.load) begin
            prev_pos_ff <= ball_pos;
         end
         if (cmd.div_init) begin
            prev_err_ff <= PERR_W'(err_ff);
         end
         if (cmd.integ_upd) begin
            integ_ff <= integ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         err_ff <= err_wide[ERR_W-1:0];
         dt_ff  <= (dt_ms == '0) ? DT_W'(1) : dt_ms;
      end
      if (cmd.mul_sel != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (cmd.div_init) begin
         div_neg_ff <= div_diff[PERR_W-1];
         div_num_ff <= div_diff[PERR_W-1] ? PERR_W'(-div_diff) : PERR_W'(div_diff);
         div_rem_ff <= '0;
      end else if (cmd.div_step) begin
         div_num_ff <= div_num_in;
         div_rem_ff <= div_rem_in;
      end
      if (cmd.clamp) begin
         lim_ff   <= lim;
         over_ff  <= acc_ff >= hi_th;
         under_ff <= acc_ff < lo_th;
         u_ff     <= u_wide[U_W-1:0];
      end
      if (cmd.code_set) begin
         code_ff <= code_in;
      end
      if (cmd.split) begin
         hi_ff  <= hi_in;
         rem_ff <= rem_in;
      end
      if (cmd.mid_set) begin
         mid_ff <= prod_ff[RECIP100_SHIFT+DIGIT_W-1:RECIP100_SHIFT];
      end
      if (cmd.lo_set) begin
         lo_ff <= DIGIT_W'(rem_ff - prod_ff[REM_W-1:0]);
      end
   end

   always_comb begin
      case (cmd.byte_idx)
         BYTE_CMD: tx_byte = CMD_TILT;
         BYTE_HI:  tx_byte = BYTE_W'(hi_ff);
         BYTE_MID: tx_byte = BYTE_W'(mid_ff);
         BYTE_LO:  tx_byte = BYTE_W'(lo_ff);
         default:  tx_byte = TERMINATOR;
      endcase
   end

   assign rsp_tdata = {1'b0, code_ff, tx_byte};

endmodule

@@ rtl/bbpid_ctrl.sv @@
// Controller state machine of the ball balance PID frame block.
`include "ball_balance_pid_frame_assert.svh"

module bbpid_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_detected,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic                     rsp_tlast,
   output bbpid_pkg::bbpid_cmd_type cmd
);
   import bbpid_pkg::*;

   localparam int STATE_W = 5;
   localparam logic [STATE_W-1:0] S_IDLE   = 5'd0;
   localparam logic [STATE_W-1:0] S_PREP   = 5'd1;
   localparam logic [STATE_W-1:0] S_INTEG  = 5'd2;
   localparam logic [STATE_W-1:0] S_ACC0   = 5'd3;
   localparam logic [STATE_W-1:0] S_ACC1   = 5'd4;
   localparam logic [STATE_W-1:0] S_ACC2   = 5'd5;
   localparam logic [STATE_W-1:0] S_DIV    = 5'd6;
   localparam logic [STATE_W-1:0] S_DMUL   = 5'd7;
   localparam logic [STATE_W-1:0] S_ACC3   = 5'd8;
   localparam logic [STATE_W-1:0] S_CLAMP  = 5'd9;
   localparam logic [STATE_W-1:0] S_RECIP  = 5'd10;
   localparam logic [STATE_W-1:0] S_CODE   = 5'd11;
   localparam logic [STATE_W-1:0] S_SPLIT  = 5'd12;
   localparam logic [STATE_W-1:0] S_MULMID = 5'd13;
   localparam logic [STATE_W-1:0] S_MID    = 5'd14;
   localparam logic [STATE_W-1:0] S_MULLO  = 5'd15;
   localparam logic [STATE_W-1:0] S_LO     = 5'd16;
   localparam logic [STATE_W-1:0] S_SEND   = 5'd17;

   logic [STATE_W-1:0]    state_ff;
   logic [STATE_W-1:0]    state_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_in;
   logic [BYTE_IDX_W-1:0] byte_idx_ff;
   logic [BYTE_IDX_W-1:0] byte_idx_in;
   logic                  req_accept;
   logic                  rsp_accept;

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = state_ff == S_SEND;
   assign rsp_tlast  = rsp_tvalid && (byte_idx_ff == BYTE_TERM);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      byte_idx_in  = byte_idx_ff;
      cmd          = '0;
      cmd.mul_sel  = MUL_NONE;
      cmd.acc_op   = ACC_HOLD;
      cmd.byte_idx = byte_idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_detected) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.div_init = 1'b1;
            cmd.mul_sel  = MUL_ERR_DT;
            div_cnt_in   = '0;
            state_in     = S_INTEG;
         end
         S_INTEG: begin
            cmd.integ_upd = 1'b1;
            cmd.mul_sel   = MUL_PG_ERR;
            state_in      = S_ACC0;
         end
         S_ACC0: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = MUL_IG_LO;
            state_in    = S_ACC1;
         end
         S_ACC1: begin
            cmd.acc_op  = ACC_ADD;
            cmd.mul_sel = MUL_IG_HI;
            state_in    = S_ACC2;
         end
         S_ACC2: begin
            cmd.acc_op = ACC_ADD_HI;
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(DIV_BITS - 1)) begin
               state_in = S_DMUL;
            end
         end
         S_DMUL: begin
            cmd.mul_sel = MUL_DG_DERIV;
            state_in    = S_ACC3;
         end
         S_ACC3: begin
            cmd.acc_op = ACC_ADD;
            state_in   = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_RECIP;
         end
         S_RECIP: begin
            cmd.mul_sel = MUL_RECIP5;
            state_in    = S_CODE;
         end
         S_CODE: begin
            cmd.code_set = 1'b1;
            state_in     = S_SPLIT;
         end
         S_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = S_MULMID;
         end
         S_MULMID: begin
            cmd.mul_sel = MUL_RECIP100;
            state_in    = S_MID;
         end
         S_MID: begin
            cmd.mid_set = 1'b1;
            state_in    = S_MULLO;
         end
         S_MULLO: begin
            cmd.mul_sel = MUL_BASE100;
            state_in    = S_LO;
         end
         S_LO: begin
            cmd.lo_set  = 1'b1;
            byte_idx_in = BYTE_CMD;
            state_in    = S_SEND;
         end
         S_SEND: begin
            if (rsp_accept) begin
               if (byte_idx_ff == BYTE_TERM) begin
                  byte_idx_in = BYTE_CMD;
                  state_in    = S_IDLE;
               end else begin
                  byte_idx_in = byte_idx_ff + BYTE_IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         div_cnt_ff  <= '0;
         byte_idx_ff <= BYTE_CMD;
      end else begin
         state_ff    <= state_in;
         div_cnt_ff  <= div_cnt_in;
         byte_idx_ff <= byte_idx_in;
      end
   end

   `BBPID_ASSERT_SAME(a_one_at_a_time, clock, reset, rsp_tvalid, !req_tready, "input taken while a frame is being sent")
   `BBPID_ASSERT_NEXT(a_detected_starts, clock, reset, req_accept && req_detected, state_ff == S_PREP, "detected transaction did not start the computation")
   `BBPID_ASSERT_NEXT(a_undetected_ignored, clock, reset, req_accept && !req_detected, state_ff == S_IDLE, "undetected transaction was not ignored")
   `BBPID_ASSERT_NEXT(a_last_returns_idle, clock, reset, rsp_accept && rsp_tlast, state_ff == S_IDLE, "controller did not return to idle after the terminator")

endmodule

@@ rtl/ball_balance_pid_frame.sv @@
// Top level of the ball balance PID frame block.
// Each request transaction carries one camera frame; frames with detected low are taken and
// give nothing. A detected frame runs a cascaded PID step on one shared multiplier and
// accumulator and then sends five response transactions: 1, the three base-100 digits of the
// tilt code (tilt plus 9000 centidegrees), and 0xFF with tlast high. The derivative term is
// formed by a one-bit-per-cycle divider. A new frame is taken only once the terminator byte
// has been accepted. Configuration writes take effect at once and are meant for idle periods.
module ball_balance_pid_frame (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // ball_pos[13:0], target_pos[27:14], dt_ms[37:28], zero padding[39:38].
   input  logic [bbpid_pkg::REQ_DATA_W-1:0] req_tdata,
   // detected[0].
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tx_byte[7:0], angle_code[22:8], zero padding[23].
   output logic [bbpid_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [bbpid_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [bbpid_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bbpid_pkg::*;

   bbpid_cmd_type cmd;

   bbpid_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_detected (req_tuser),
      .req_tready   (req_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tlast    (rsp_tlast),
      .cmd          (cmd)
   );

   bbpid_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .rsp_tdata (rsp_tdata)
   );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the ball balance PID frame block, checked against its own predictor.
`timescale 1ns / 100ps
module tb_top;
   import bbpid_pkg::*;

   localparam int     POS_TOP        = 10239;
   localparam int     VEL_SCALE      = 60;
   localparam int     SETPOINT_SCALE = 4;
   localparam int     DRAIN_CYCLES   = 50;
   localparam int     STALL_LIMIT    = 2000;
   localparam int     SAT_PAIRS      = 30;
   localparam int     PHASE_FRAMES   = 70;
   localparam int     NO_CODE        = -1;
   localparam longint INTEG_TOP      = (longint'(1) <<< (INTEG_W - 1)) - 1;
   localparam longint INTEG_BOTTOM   = -INTEG_TOP - 1;

   typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [CSR_ADDR_W-1:0]   addr;
      logic [CSR_DATA_W-1:0]   wdata;
      logic [POS_W-1:0]        ball;
      logic [POS_W-1:0]        target;
      logic [DT_W-1:0]         dt;
      logic                    det;
      int                      angle;
   } stim_row_type;

   typedef struct packed {
      logic [BYTE_W-1:0] tx_byte;
      logic              frame_end;
      logic [CODE_W-1:0] angle_code;
   } tx_beat_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int n_errors = 0;

   longint kp         = longint'(PROP_GAIN_RESET);
   longint ki         = longint'(INTEG_GAIN_RESET);
   longint kd         = longint'(DERIV_GAIN_RESET);
   longint tilt_clamp = longint'(TILT_LIMIT_RESET);
   longint last_pos     = 0;
   longint last_error   = 0;
   longint err_integral = 0;

   tx_beat_type pending_tx[$];

   stim_row_type directed_rows [25] = '{
      '{ROW_FRAME, CSR_PROP_GAIN,  16'd0,     14'd0,     14'd0,     10'd1,    1'b1, TILT_OFFSET},
      '{ROW_FRAME, CSR_PROP_GAIN,  16'd0,     14'd10239, 14'd10239, 10'd1023, 1'b0, NO_CODE},
      '{ROW_FRAME, CSR_PROP_GAIN,  16'd0,     14'd0,     14'd0,     10'd1,    1'b1, TILT_OFFSET},
      '{ROW_FRAME, CSR_PROP_GAIN,  16'd0,     14'd100,   14'd200,   10'd0,    1'b1, NO_CODE},
      '{ROW_FRAME, CSR_PROP_GAIN,  16'd0,     14'd10239, 14'd10239, 10'd1023, 1'b1, NO_CODE},
      '{ROW_WRITE, CSR_TILT_LIMIT, 16'd0,     14'd0,     14'd0,     10'd0,    1'b0, NO_CODE},
      '{ROW_FRAME, CSR_PROP_GAIN,  16'd0,     14'd10239, 14'd0,     10'd5,    1'b1, TILT_OFFSET},
      '{ROW_FRAME, CSR_PROP_GAIN,  16'd0,     14'd0,     14'd10239, 10'd17,   1'b1, TILT_OFFSET},
      '{ROW_WRITE, CSR_TILT_LIMIT, 16'hFFFF,  14'd0,     14'd0,     10'd0,    1'b0, NO_CODE},
      '{ROW_FRAME, CSR_PROP_GAIN,  16'd0,     14'd10239, 14'd0,     10'd1,    1'b1, 0},
      '{ROW_FRAME, CSR_PROP_GAIN,  16'd0,     14'd10239, 14'd10239, 10'd1,    1'b1, NO_CODE},
      '{ROW_WRITE, CSR_PROP_GAIN,  16'd0,     14'd0,     14'd0,     10'd0,    1'b0, NO_CODE},
      '{ROW_WRITE, CSR_INTEG_GAIN, 16'd0,     14'd0,     14'd0,     10'd0,    1'b0, NO_CODE},
      '{ROW_WRITE, CSR_DERIV_GAIN, 16'd0,     14'd0,     14'd0,     10'd0,    1'b0, NO_CODE},
      '{ROW_FRAME, CSR_PROP_GAIN,  16'd0,     14'd5000,  14'd3000,  10'd300,  1'b1, TILT_OFFSET},
      '{ROW_WRITE, CSR_PROP_GAIN,  16'hFFFF,  14'd0,     14'd0,     10'd0,    1'b0, NO_CODE},
      '{ROW_WRITE, CSR_INTEG_GAIN, 16'hFFFF,  14'd0,     14'd0,     10'd0,    1'b0, NO_CODE},
      '{ROW_WRITE, CSR_DERIV_GAIN, 16'hFFFF,  14'd0,     14'd0,     10'd0,    1'b0, NO_CODE},
      '{ROW_WRITE, CSR_TILT_LIMIT, 16'd9000,  14'd0,     14'd0,     10'd0,    1'b0, NO_CODE},
      '{ROW_FRAME, CSR_PROP_GAIN,  16'd0,     14'd5001,  14'd5000,  10'd1,    1'b1, NO_CODE},
      '{ROW_FRAME, CSR_PROP_GAIN,  16'd0,     14'd5000,  14'd5000,  10'd1023, 1'b1, NO_CODE},
      '{ROW_WRITE, CSR_DERIV_GAIN, 16'd0,     14'd0,     14'd0,     10'd0,    1'b0, NO_CODE},
      '{ROW_FRAME, CSR_PROP_GAIN,  16'd0,     14'd5003,  14'd5000,  10'd2,    1'b1, NO_CODE},
      '{ROW_WRITE, CSR_TILT_LIMIT, 16'd1,     14'd0,     14'd0,     10'd0,    1'b0, NO_CODE},
      '{ROW_FRAME, CSR_PROP_GAIN,  16'd0,     14'd5003,  14'd5003,  10'd1023, 1'b1, NO_CODE}
   };

   ball_balance_pid_frame u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void predict_tilt_frame(input logic [POS_W-1:0] ball_pos,
                                              input logic [POS_W-1:0] target_pos,
                                              input logic [DT_W-1:0] dt_ms,
                                              input int typed_angle);
      longint ball, target, dt, err, integ, deriv, ctrl, divisor, tilt, lim, code;
      logic [BYTE_W-1:0] frame_bytes [5];
      tx_beat_type beat;
      ball = longint'(ball_pos);
      target = longint'(target_pos);
      dt = (dt_ms == '0) ? 1 : longint'(dt_ms);
      err = (target - ball) * SETPOINT_SCALE - (ball - last_pos) * VEL_SCALE;
      integ = err_integral + err * dt;
      if (integ > INTEG_TOP) integ = INTEG_TOP;
      if (integ < INTEG_BOTTOM) integ = INTEG_BOTTOM;
      if (ki == 0) integ = 0;
      deriv = (kd == 0) ? 0 : (err - last_error) / dt;
      ctrl = kp * err + ki * integ + kd * deriv;
      divisor = longint'(5) <<< TILT_SHIFT;
      tilt = ctrl / divisor;
      if (ctrl % divisor != 0 && ctrl < 0) tilt = tilt - 1;
      lim = (tilt_clamp > TILT_MAX) ? longint'(TILT_MAX) : tilt_clamp;
      if (tilt > lim) tilt = lim;
      if (tilt < -lim) tilt = -lim;
      code = tilt + TILT_OFFSET;
      if (typed_angle != NO_CODE) code = typed_angle;
      err_integral = integ;
      last_error = err;
      last_pos = ball;
      frame_bytes[0] = CMD_TILT;
      frame_bytes[1] = BYTE_W'(code / HI_BASE);
      frame_bytes[2] = BYTE_W'((code % HI_BASE) / DIGIT_BASE);
      frame_bytes[3] = BYTE_W'(code % DIGIT_BASE);
      frame_bytes[4] = TERMINATOR;
      for (int k = 0; k < 5; k++) begin
         beat.tx_byte = frame_bytes[k];
         beat.frame_end = (k == 4);
         beat.angle_code = CODE_W'(code);
         pending_tx.push_back(beat);
      end
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain(input int cap);
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      if (roll == 2) return GAIN_W'($urandom);
      return GAIN_W'($urandom_range(0, cap));
   endfunction

   task automatic send_frame(input logic [POS_W-1:0] ball, input logic [POS_W-1:0] target,
                             input logic [DT_W-1:0] dt, input logic det, input int angle);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {2'b00, dt, target, ball};
      req_tuser = det;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (det) predict_tilt_frame(ball, target, dt, angle);
   endtask

   // Lowers the request, lets every expected transaction arrive, then lets the block go quiet.
   task automatic settle_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_tx.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = addr;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (addr)
         CSR_PROP_GAIN: begin
            kp = longint'(data);
         end
         CSR_INTEG_GAIN: begin
            ki = longint'(data);
         end
         CSR_DERIV_GAIN: begin
            kd = longint'(data);
         end
         CSR_TILT_LIMIT: begin
            tilt_clamp = longint'(data[LIMIT_W-1:0]);
         end
         default: begin
         end
      endcase
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      tx_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_tx.size() == 0) begin
            n_errors++;
            $display("%0t unexpected response transaction: byte %0d end %0b code %0d",
                     $time, rsp_tdata[7:0], rsp_tlast, rsp_tdata[22:8]);
         end else begin
            want = pending_tx.pop_front();
            if (want.tx_byte !== rsp_tdata[7:0] || want.frame_end !== rsp_tlast ||
                want.angle_code !== rsp_tdata[22:8]) begin
               n_errors++;
               $display("%0t mismatch: expected byte %0d end %0b code %0d, got byte %0d end %0b code %0d",
                        $time, want.tx_byte, want.frame_end, want.angle_code,
                        rsp_tdata[7:0], rsp_tlast, rsp_tdata[22:8]);
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      int n_det, roll, ball, target, walk;
      logic [DT_W-1:0] dt;
      logic det;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            settle_idle();
            write_reg(directed_rows[i].addr, directed_rows[i].wdata);
         end else begin
            send_frame(directed_rows[i].ball, directed_rows[i].target, directed_rows[i].dt,
                       directed_rows[i].det, directed_rows[i].angle);
         end
      end

      // Slow moves one way and fast moves back build up a large integral, first negative,
      // then, after a clearing frame, positive.
      settle_idle();
      write_reg(CSR_PROP_GAIN, PROP_GAIN_RESET);
      write_reg(CSR_INTEG_GAIN, INTEG_GAIN_RESET);
      write_reg(CSR_DERIV_GAIN, DERIV_GAIN_RESET);
      write_reg(CSR_TILT_LIMIT, CSR_DATA_W'(TILT_LIMIT_RESET));
      for (int side = 0; side < 2; side++) begin
         for (int p = 0; p < SAT_PAIRS; p++) begin
            if (side == 0) begin
               send_frame(POS_W'(POS_TOP), '0, '1, 1'b1, NO_CODE);
               send_frame('0, '0, DT_W'(1), 1'b1, NO_CODE);
            end else begin
               send_frame('0, POS_W'(POS_TOP), '1, 1'b1, NO_CODE);
               send_frame(POS_W'(POS_TOP), POS_W'(POS_TOP), DT_W'(1), 1'b1, NO_CODE);
            end
         end
         if (side == 0) begin
            settle_idle();
            write_reg(CSR_INTEG_GAIN, '0);
            send_frame(POS_W'(POS_TOP), POS_W'(POS_TOP), DT_W'(1), 1'b1, NO_CODE);
            settle_idle();
            write_reg(CSR_INTEG_GAIN, INTEG_GAIN_RESET);
         end
      end

      for (int ph = 0; ph < 4; ph++) begin
         settle_idle();
         write_reg(CSR_PROP_GAIN, pick_gain(400));
         write_reg(CSR_INTEG_GAIN, pick_gain(8));
         write_reg(CSR_DERIV_GAIN, pick_gain(400));
         roll = $urandom_range(9);
         if (roll == 0) begin
            write_reg(CSR_TILT_LIMIT, '0);
         end else if (roll == 1) begin
            write_reg(CSR_TILT_LIMIT, CSR_DATA_W'(TILT_MAX));
         end else if (roll == 2) begin
            write_reg(CSR_TILT_LIMIT, CSR_DATA_W'($urandom_range(TILT_MAX + 1, 16383)));
         end else begin
            write_reg(CSR_TILT_LIMIT, CSR_DATA_W'($urandom_range(1, TILT_MAX)));
         end
         case (ph)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 61;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 61;
            end
            default: begin
               send_idle_pct = 22;
               recv_stall_pct = 22;
            end
         endcase
         walk = $urandom_range(0, POS_TOP);
         n_det = 0;
         while (n_det < PHASE_FRAMES) begin
            roll = $urandom_range(99);
            if (roll < 60) begin
               ball = walk + int'($urandom_range(0, 64)) - 32;
               ball = (ball < 0) ? 0 : (ball > POS_TOP) ? POS_TOP : ball;
               target = ball + int'($urandom_range(0, 800)) - 400;
               target = (target < 0) ? 0 : (target > POS_TOP) ? POS_TOP : target;
               dt = DT_W'($urandom_range(1, 40));
               det = 1'b1;
               walk = ball;
            end else begin
               ball = $urandom_range(0, POS_TOP);
               target = $urandom_range(0, POS_TOP);
               dt = DT_W'($urandom_range(0, 1023));
               det = (roll < 85);
               if (det) walk = ball;
            end
            if (det) begin
               n_det++;
               if (n_det == PHASE_FRAMES / 2) settle_idle();
            end
            send_frame(POS_W'(ball), POS_W'(target), dt, det, NO_CODE);
         end
      end

      settle_idle();
      if (n_errors == 0 && pending_tx.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
